// File: design/barometer_temp_pressure_compensation_core_macros.svh
// assertion helpers for the checker file btpc_chk.sv
`ifndef BAROMETER_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BAROMETER_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication
`define BTPC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("btpc check failed");

// next-cycle implication
`define BTPC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("btpc check failed");

`endif

// File: design/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Types, register indexes and helper functions of the compensation core.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	// datapath step codes, executed in order unless the controller branches
	typedef enum logic [4:0] {
		S_T1, S_T2, S_T3, S_TQ, S_T4,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
		S_P11, S_P12, S_PQ, S_P13, S_P14, S_P15, S_P16, S_P17,
		S_ERR
	} step_t;

	typedef struct packed {
		logic  en;
		logic  load;
		step_t step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic b4_zero;
		logic div_done;
	} dp_stat_t;

	function automatic logic [31:0] sext16(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	// signed divide by 2^k, truncating toward zero
	function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input int unsigned k);
		logic [31:0] bias;
		bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
		return 32'($signed(x + bias) >>> k);
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

endpackage

// File: design/btpc_if.sv
// ----------------------------------------------------------------------------
// btpc channel interfaces
// Valid/ready channels for raw readings, results and register writes.
// ----------------------------------------------------------------------------
interface btpc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [23:0] raw_reading;
	modport source (output valid, cmd, raw_reading, input ready);
	modport sink (input valid, cmd, raw_reading, output ready);
endinterface

interface btpc_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] value;
	logic        divide_error;
	modport source (output valid, kind, value, divide_error, input ready);
	modport sink (input valid, kind, value, divide_error, output ready);
endinterface

interface btpc_cfg_if;
	import btpc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/btpc_div.sv
// ----------------------------------------------------------------------------
// btpc_div
// Unsigned 32 by 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module btpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// File: design/btpc_dpath.sv
// ----------------------------------------------------------------------------
// btpc_dpath
// Calibration registers, shared multiplier, divider and working registers.
// ----------------------------------------------------------------------------
module btpc_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  btpc_pkg::ctrl_cmd_t            cmd,
	output btpc_pkg::dp_stat_t             stat,
	input  logic                           in_cmd,
	input  logic [23:0]                    in_raw,
	input  logic                           cfg_we,
	input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic                           res_kind,
	output logic [31:0]                    res_value,
	output logic                           res_err
);
	import btpc_pkg::*;

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;
	logic        cmd_q;
	logic [23:0] raw_q;
	logic [31:0] b5_q;
	logic [31:0] mul_q, x1_q, x2_q, t_q, b3_q, b4_q, b6_q, sq_q, up_q, p_q;
	logic        neg_q, dbl_q;
	logic        kind_q, err_q;
	logic [31:0] value_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] ma, mb, den, mc_sh, dvd, dvs, quo, sum12;
	logic        div_start, div_done;

	assign ac1 = sext16(ac12_q[31:16]);
	assign ac2 = sext16(ac12_q[15:0]);
	assign ac3 = sext16(ac34_q[31:16]);
	assign ac4 = {16'd0, ac34_q[15:0]};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = sext16(b12_q[31:16]);
	assign b2  = sext16(b12_q[15:0]);
	assign mc  = sext16(mcmd_q[31:16]);
	assign md  = sext16(mcmd_q[15:0]);

	assign den   = x1_q + md;
	assign mc_sh = mc << 11;
	assign sum12 = x1_q + x2_q;

	assign stat.den_zero = (den == 32'd0);
	assign stat.b4_zero  = (b4_q == 32'd0);
	assign stat.div_done = div_done;

	// temperature divides signed magnitudes, pressure divides b7 (doubled when it fits)
	always_comb begin
		if (cmd.step == S_T3) begin
			dvd = abs32(mc_sh);
			dvs = abs32(den);
		end else begin
			dvd = mul_q[31] ? mul_q : (mul_q << 1);
			dvs = b4_q;
		end
	end

	assign div_start = cmd.en && (((cmd.step == S_T3) && !stat.den_zero) ||
		((cmd.step == S_P12) && !stat.b4_zero));

	btpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (div_done)
	);

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.step)
			S_T1: begin
				ma = {16'd0, raw_q[15:0]} - ac6;
				mb = ac5;
			end
			S_P2: begin
				ma = b6_q;
				mb = b6_q;
			end
			S_P4: begin
				ma = b2;
				mb = sq_q;
			end
			S_P5: begin
				ma = ac2;
				mb = b6_q;
			end
			S_P6: begin
				ma = ac3;
				mb = b6_q;
			end
			S_P7: begin
				ma = b1;
				mb = sq_q;
			end
			S_P10: begin
				ma = ac4;
				mb = t_q + 32'd32768;
			end
			S_P11: begin
				ma = up_q - b3_q;
				mb = 32'd50000 >> oss_q;
			end
			S_P13: begin
				ma = sdiv_p2(p_q, 8);
				mb = sdiv_p2(p_q, 8);
			end
			S_P14: begin
				ma = mul_q;
				mb = 32'd3038;
			end
			S_P15: begin
				ma = 32'hFFFF_E343;
				mb = p_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= 2'd3;
			b5_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AC1_AC2: ac12_q <= cfg_data;
					REG_AC3_AC4: ac34_q <= cfg_data;
					REG_AC5_AC6: ac56_q <= cfg_data;
					REG_B1_B2:   b12_q  <= cfg_data;
					REG_MC_MD:   mcmd_q <= cfg_data;
					REG_OSS:     oss_q  <= cfg_data[1:0];
					default:     ;
				endcase
			end
			if (cmd.en && (cmd.step == S_T4)) begin
				b5_q <= sum12;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			raw_q <= in_raw;
		end
		if (cmd.en) begin
			mul_q <= 32'(ma * mb);
			unique case (cmd.step)
				S_T2:  x1_q <= sdiv_p2(mul_q, 15);
				S_T3:  neg_q <= mc_sh[31] ^ den[31];
				S_TQ:  x2_q <= neg_q ? (32'd0 - quo) : quo;
				S_T4: begin
					value_q <= sdiv_p2(sum12 + 32'd8, 4);
					err_q   <= 1'b0;
					kind_q  <= CMD_TEMP;
				end
				S_P1: begin
					b6_q <= b5_q - 32'd4000;
					up_q <= {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
				end
				S_P3:  sq_q <= sdiv_p2(mul_q, 12);
				S_P5:  x1_q <= sdiv_p2(mul_q, 11);
				S_P6:  x2_q <= sdiv_p2(mul_q, 11);
				S_P7: begin
					t_q  <= (ac1 << 2) + sum12;
					x1_q <= sdiv_p2(mul_q, 13);
				end
				S_P8: begin
					b3_q <= sdiv_p2((t_q << oss_q) + 32'd2, 2);
					x2_q <= sdiv_p2(mul_q, 16);
				end
				S_P9:  t_q <= sdiv_p2(sum12 + 32'd2, 2);
				S_P11: b4_q <= mul_q >> 15;
				S_P12: dbl_q <= mul_q[31];
				S_PQ:  p_q <= dbl_q ? (quo << 1) : quo;
				S_P15: x1_q <= sdiv_p2(mul_q, 16);
				S_P16: x2_q <= sdiv_p2(mul_q, 16);
				S_P17: begin
					value_q <= p_q + sdiv_p2(sum12 + 32'd3791, 4);
					err_q   <= 1'b0;
					kind_q  <= CMD_PRESS;
				end
				S_ERR: begin
					value_q <= '0;
					err_q   <= 1'b1;
					kind_q  <= cmd_q;
				end
				default: ;
			endcase
		end
	end

	assign res_kind  = kind_q;
	assign res_value = value_q;
	assign res_err   = err_q;
endmodule

// File: design/btpc_ctrl.sv
// ----------------------------------------------------------------------------
// btpc_ctrl
// Sequencer: walks the datapath through the steps of one reading.
// ----------------------------------------------------------------------------
module btpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output btpc_pkg::ctrl_cmd_t cmd,
	input  btpc_pkg::dp_stat_t  stat
);
	import btpc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DIVW = 3'b100
	} state_t;

	state_t state_q;
	step_t  step_q;
	logic   out_valid_q;
	logic   finish, stall, exec, in_acc;

	assign finish = (step_q == S_T4) || (step_q == S_P17) || (step_q == S_ERR);
	// the result register still holds a word nobody took
	assign stall  = finish && out_valid_q && !out_ready;
	assign exec   = (state_q == ST_RUN) && !stall;
	assign in_acc = in_valid && in_ready;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.en    = exec;
	assign cmd.load  = in_acc;
	assign cmd.step  = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= S_T1;
			out_valid_q <= 1'b0;
		end else begin
			if (exec && finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						step_q  <= (in_cmd == CMD_TEMP) ? S_T1 : S_P1;
					end
				end
				ST_RUN: begin
					if (exec) begin
						if (finish) begin
							state_q <= ST_IDLE;
						end else if (step_q == S_T3) begin
							if (stat.den_zero) begin
								step_q <= S_ERR;
							end else begin
								state_q <= ST_DIVW;
							end
						end else if (step_q == S_P12) begin
							if (stat.b4_zero) begin
								step_q <= S_ERR;
							end else begin
								state_q <= ST_DIVW;
							end
						end else begin
							step_q <= step_t'(step_q + 5'd1);
						end
					end
				end
				ST_DIVW: begin
					if (stat.div_done) begin
						state_q <= ST_RUN;
						step_q  <= step_t'(step_q + 5'd1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: design/barometer_temp_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation_core
// Integer compensation of raw barometer temperature and pressure readings.
// ----------------------------------------------------------------------------
// usage:
// - cfg: write calibration words (index 0..4) and oversampling (index 5)
//   while the core is idle; cfg.ready is always high, other indexes ignored
// - req: one word per reading, cmd 0 temperature, cmd 1 pressure; a
//   temperature reading also updates the stored b5 used by later pressures
// - rsp: one word per reading with kind, value and divide_error
// sequence: a pressure reading runs more steps than a temperature reading;
//   most of the time goes to the bit-serial divider, the rest is one
//   multiply or add step per cycle while the result register is free
// throughput: one reading at a time; req.ready is high only while idle,
//   so a new reading is accepted only after the last one has finished
// a zero divisor skips the divider and the remaining steps and gives the result early
// reset clears calibration to zero, oversampling to 3 and b5 to zero
// rsp stall: the result word holds until taken; a following reading runs
//   up to its last step and waits there for the result register
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation_core (
	input  logic       clk,
	input  logic       arst_n,
	btpc_in_if.sink    req,
	btpc_out_if.source rsp,
	btpc_cfg_if.sink   cfg
);
	import btpc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg.ready = 1'b1;

	btpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_cmd    (req.cmd),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	btpc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_cmd    (req.cmd),
		.in_raw    (req.raw_reading),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res_kind  (rsp.kind),
		.res_value (rsp.value),
		.res_err   (rsp.divide_error)
	);
endmodule

// File: design/btpc_chk.sv
// ----------------------------------------------------------------------------
// btpc_chk
// Port-level checks of the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
`include "barometer_temp_pressure_compensation_core_macros.svh"

module btpc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_value,
	input logic        rsp_err,
	input logic        cfg_ready
);
	`BTPC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
	`BTPC_ASSERT_IMP(a_err_zero, clk, arst_n, rsp_valid && rsp_err, rsp_value == 32'd0)
	`BTPC_ASSERT_IMP(a_cfg_rdy, clk, arst_n, 1'b1, cfg_ready)
	`BTPC_ASSERT_NXT(a_one_item, clk, arst_n, req_valid && req_ready, !req_ready)
endmodule

bind barometer_temp_pressure_compensation_core btpc_chk u_btpc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value),
	.rsp_err   (rsp.divide_error),
	.cfg_ready (cfg.ready)
);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometer compensation core. Readings go in
// through a bursty driver, results are taken under a stalling receiver and
// checked word by word against a predictor of the integer compensation.
// ----------------------------------------------------------------------------
module tb_top;
	import btpc_pkg::*;

	typedef struct packed {
		logic        cmd;
		logic [23:0] raw;
	} reading_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic        err;
	} comp_t;

	logic clk;
	logic arst_n;

	btpc_in_if  req();
	btpc_out_if rsp();
	btpc_cfg_if cfg();

	barometer_temp_pressure_compensation_core DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	// predictor copy of registers and stored b5
	logic [31:0] m_ac12, m_ac34, m_ac56, m_b12, m_mcmd;
	logic [1:0]  m_oss;
	int          m_b5;

	reading_t pending_q[$];
	reading_t sent_q[$];
	comp_t    expected_q[$];
	int       mismatch_cnt;
	int       idle_cycles;
	int       burst_left;
	int       gap_left;
	int       stall_mode;
	bit       hold_off;
	bit       stim_done;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// truncating divide, wrapping most negative / -1
	function automatic int tdiv(input int a, input int b);
		if (b == -1)
			return -a;
		return a / b;
	endfunction

	function automatic int shi(input logic [31:0] r);
		return int'($signed(r[31:16]));
	endfunction

	function automatic int slo(input logic [31:0] r);
		return int'($signed(r[15:0]));
	endfunction

	function automatic comp_t compensate(input reading_t rd);
		comp_t res;
		int ut, x1, x2, x3, den, b6, sq, t, b3, pr, q;
		logic [31:0] up, b4, b7, p, ac4, ac5, ac6;
		ac4 = {16'd0, m_ac34[15:0]};
		ac5 = {16'd0, m_ac56[31:16]};
		ac6 = {16'd0, m_ac56[15:0]};
		res.kind = rd.cmd;
		res.value = 32'd0;
		res.err = 1'b0;
		if (rd.cmd == CMD_TEMP) begin
			ut = int'({16'd0, rd.raw[15:0]});
			x1 = tdiv((ut - int'(ac6)) * int'(ac5), 32768);
			den = x1 + slo(m_mcmd);
			if (den == 0) begin
				res.err = 1'b1;
			end else begin
				x2 = tdiv(shi(m_mcmd) * 2048, den);
				m_b5 = x1 + x2;
				res.value = tdiv(m_b5 + 8, 16);
			end
		end else begin
			up = {8'd0, rd.raw} >> (8 - m_oss);
			b6 = m_b5 - 4000;
			sq = tdiv(b6 * b6, 4096);
			x1 = tdiv(slo(m_b12) * sq, 2048);
			x2 = tdiv(slo(m_ac12) * b6, 2048);
			x3 = x1 + x2;
			t = shi(m_ac12) * 4 + x3;
			b3 = tdiv((t << m_oss) + 2, 4);
			x1 = tdiv(shi(m_ac34) * b6, 8192);
			x2 = tdiv(shi(m_b12) * sq, 65536);
			x3 = tdiv(x1 + x2 + 2, 4);
			b4 = (ac4 * (x3 + 32768)) / 32'd32768;
			b7 = (up - b3) * (32'd50000 >> m_oss);
			if (b4 == 0) begin
				res.err = 1'b1;
			end else begin
				if (!b7[31])
					p = (b7 * 2) / b4;
				else
					p = (b7 / b4) * 2;
				pr = int'(p);
				q = tdiv(pr, 256);
				x1 = tdiv(q * q * 3038, 65536);
				x2 = tdiv(-7357 * pr, 65536);
				res.value = pr + tdiv(x1 + x2 + 3791, 16);
			end
		end
		return res;
	endfunction

	task automatic wait_drained();
		while (pending_q.size() != 0 || sent_q.size() != 0 || expected_q.size() != 0
				|| req.valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_AC1_AC2: m_ac12 = d;
			REG_AC3_AC4: m_ac34 = d;
			REG_AC5_AC6: m_ac56 = d;
			REG_B1_B2:   m_b12 = d;
			REG_MC_MD:   m_mcmd = d;
			REG_OSS:     m_oss = d[1:0];
			default: ;
		endcase
	endtask

	task automatic load_cal(input int kind);
		case (kind)
			0: begin
				// typical factory coefficients
				write_reg(REG_AC1_AC2, {16'd408, -16'sd72});
				write_reg(REG_AC3_AC4, {-16'sd14383, 16'd32741});
				write_reg(REG_AC5_AC6, {16'd32757, 16'd23153});
				write_reg(REG_B1_B2, {16'd6190, 16'd4});
				write_reg(REG_MC_MD, {-16'sd8711, 16'd2868});
			end
			1: begin
				write_reg(REG_AC1_AC2, 32'hFFFF_FFFF);
				write_reg(REG_AC3_AC4, 32'h8000_FFFF);
				write_reg(REG_AC5_AC6, 32'hFFFF_FFFF);
				write_reg(REG_B1_B2, 32'h7FFF_8000);
				write_reg(REG_MC_MD, 32'h8000_7FFF);
			end
			2: begin
				// zero ac4, ac5, ac6 and md force both divisor-zero paths
				write_reg(REG_AC1_AC2, $urandom);
				write_reg(REG_AC3_AC4, {16'($urandom_range(65535, 0)), 16'd0});
				write_reg(REG_AC5_AC6, 32'd0);
				write_reg(REG_B1_B2, $urandom);
				write_reg(REG_MC_MD, {16'($urandom_range(65535, 0)), 16'd0});
			end
			default: begin
				write_reg(REG_AC1_AC2, $urandom);
				write_reg(REG_AC3_AC4, $urandom);
				write_reg(REG_AC5_AC6, $urandom);
				write_reg(REG_B1_B2, $urandom);
				write_reg(REG_MC_MD, $urandom);
			end
		endcase
	endtask

	function automatic reading_t rand_reading();
		reading_t rd;
		rd.cmd = 1'($urandom_range(1, 0));
		case ($urandom_range(5, 0))
			0: rd.raw = 24'd0;
			1: rd.raw = 24'hFF_FFFF;
			2: rd.raw = {8'($urandom_range(255, 0)),
				16'd27898 + 16'($urandom_range(8000, 0))};
			default: rd.raw = 24'($urandom);
		endcase
		return rd;
	endfunction

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= 1'b0;
			req.raw_reading <= 24'd0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req.valid && req.ready)
				sent_q.push_back({req.cmd, req.raw_reading});
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_q.size() != 0 && !hold_off) begin
					reading_t rd;
					rd = pending_q.pop_front();
					req.valid <= 1'b1;
					req.cmd <= rd.cmd;
					req.raw_reading <= rd.raw;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(12, 1);
						gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// predictions are made in accept order
	always @(posedge clk) begin
		while (sent_q.size() != 0)
			expected_q.push_back(compensate(sent_q.pop_front()));
	end

	// monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				comp_t got, exp_w;
				got = {rsp.kind, rsp.value, rsp.divide_error};
				if (expected_q.size() == 0) begin
					mismatch_cnt = mismatch_cnt + 1;
					if (mismatch_cnt <= 10)
						$display("unexpected result word kind=%0d value=%0d err=%0d",
							got.kind, $signed(got.value), got.err);
				end else begin
					exp_w = expected_q.pop_front();
					if (got !== exp_w) begin
						mismatch_cnt = mismatch_cnt + 1;
						if (mismatch_cnt <= 10)
							$display("mismatch: exp kind=%0d value=%0d err=%0d, got kind=%0d value=%0d err=%0d",
								exp_w.kind, $signed(exp_w.value), exp_w.err,
								got.kind, $signed(got.value), got.err);
					end
				end
			end
			if ($urandom_range(199, 0) == 0)
				stall_mode <= $urandom_range(2, 0);
			case (stall_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(3, 0) != 0);
				default: rsp.ready <= ($urandom_range(7, 0) == 0);
			endcase
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready) || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		reading_t rd;
		int n;
		mismatch_cnt = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		m_ac12 = 0; m_ac34 = 0; m_ac56 = 0; m_b12 = 0; m_mcmd = 0;
		m_oss = 2'd3;
		m_b5 = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: all divisors zero, pressure before any temperature
		pending_q.push_back({CMD_PRESS, 24'hFF_FFFF});
		pending_q.push_back({CMD_TEMP, 24'h00_1234});
		pending_q.push_back({CMD_PRESS, 24'd0});
		wait_drained();

		load_cal(0);
		write_reg(3'd7, 32'hDEAD_BEEF);
		write_reg(3'd6, 32'h1234_5678);
		for (int o = 0; o < 4; o++) begin
			write_reg(REG_OSS, 32'(o));
			pending_q.push_back({CMD_TEMP, 24'hAB_6C3A});
			pending_q.push_back({CMD_PRESS, 24'h5D_23A0});
			pending_q.push_back({CMD_PRESS, 24'hFF_FFFF});
			pending_q.push_back({CMD_PRESS, 24'd0});
			wait_drained();
		end
		write_reg(REG_OSS, 32'hFFFF_FFFC);
		load_cal(1);
		pending_q.push_back({CMD_TEMP, 24'h00_0000});
		pending_q.push_back({CMD_TEMP, 24'hFF_FFFF});
		pending_q.push_back({CMD_PRESS, 24'h80_0000});
		wait_drained();
		load_cal(2);
		pending_q.push_back({CMD_TEMP, 24'h12_3456});
		pending_q.push_back({CMD_PRESS, 24'h65_4321});
		wait_drained();

		// random phases across calibration sets and oversampling
		for (int ph = 0; ph < 12; ph++) begin
			load_cal((ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 2 : 3);
			write_reg(REG_OSS, $urandom_range(3, 0));
			n = 150;
			for (int i = 0; i < n; i++) begin
				rd = rand_reading();
				if (i % 6 == 0)
					rd.cmd = CMD_TEMP;
				pending_q.push_back(rd);
			end
			if (ph == 5) begin
				// sender holds off until the core has drained
				while (pending_q.size() > 75) @(posedge clk);
				hold_off = 1'b1;
				while (sent_q.size() != 0 || expected_q.size() != 0 || req.valid)
					@(posedge clk);
				hold_off = 1'b0;
			end
			wait_drained();
		end
		stim_done = 1'b1;
		if (mismatch_cnt == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/btpc_pkg.sv
design/btpc_if.sv
design/btpc_div.sv
design/btpc_dpath.sv
design/btpc_ctrl.sv
design/barometer_temp_pressure_compensation_core.sv
design/btpc_chk.sv
bench/tb_top.sv
